FILE: rtl/sha_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   localparam int DigestWords = 8;
   localparam int BlockBytes  = 64;
   localparam int CountBits   = 61;
   localparam int RoundCount  = 64;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       write_byte;
      logic [7:0] byte_value;
      logic       count_inc;
      logic       count_clear;
      logic       load_work;
      logic       round_step;
      logic       update_hash;
      logic       reload_iv;
   } cmd_type;

   typedef struct packed {
      logic [5:0] round;
   } stat_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] InitHash [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundK [RoundCount] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed0, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66b, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3580, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror(input logic [31:0] v, input int s);
      ror = (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] small0(input logic [31:0] v);
      small0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small1(input logic [31:0] v);
      small1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
   endfunction

   function automatic logic [31:0] big0(input logic [31:0] v);
      big0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] v);
      big1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sha_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
`default_nettype none
interface sha_req_if;
   import sha_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sha_rsp_if;
   import sha_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher_core.sv
// sha-256 hasher over a byte stream, top level
// usage:
//   req channel carries one word per byte: operation 0 absorbs data_byte,
//   operation 1 ends the message and pads it.
//   rsp channel returns eight 32-bit digest words after each finish, most
//   significant first, with word_index on each and last_word on the eighth.
// sequence:
//   a byte is absorbed when accepted in idle; the 64th byte of a block is
//   followed by the working register load, 64 rounds (one per cycle in a
//   single round unit) and the chaining update, with req ready held low.
//   finish takes the padding sweep plus one or two compressions, then
//   8 output words.
// reset:
//   synchronous; loads the initial hash value and clears the byte count.
// stall:
//   while rsp ready is low the current digest word holds and req ready
//   stays low until all eight words are taken.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core (
   input  wire logic clock,
   input  wire logic reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   import sha_pkg::*;

   cmd_type     cmd;
   logic [2:0]  out_sel;
   logic [5:0]  count_pos;
   logic [63:0] msg_bits;
   logic [31:0] hash_word;

   sha_control u_control (
      .clock, .reset, .req, .rsp, .count_pos, .msg_bits, .hash_word, .cmd, .out_sel);

   sha_datapath u_datapath (
      .clock, .reset, .cmd, .out_sel, .count_pos, .msg_bits, .hash_word);

endmodule
`default_nettype wire

FILE: rtl/sha_datapath.sv
// block shift register, byte counter, message schedule, round logic and chaining value
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sha_pkg::cmd_type  cmd,
   input  wire logic [2:0]        out_sel,
   output logic [5:0]             count_pos,
   output logic [63:0]            msg_bits,
   output logic [31:0]            hash_word
);
   import sha_pkg::*;

   logic [CountBits-1:0] count_ff, count_in;
   logic [31:0]          hash_ff [DigestWords];
   logic [31:0]          work_ff [DigestWords];
   logic [31:0]          sched_ff [16];
   logic [31:0]          sched_new, tmp1, tmp2;
   logic [5:0]           round_ff;
   logic [31:0]          k_word;

   assign count_pos = count_ff[5:0];
   assign msg_bits  = {count_ff, 3'b000};
   assign hash_word = hash_ff[out_sel];

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign k_word    = RoundK[round_ff];
   assign sched_new = small1(sched_ff[14]) + sched_ff[9] + small0(sched_ff[1]) + sched_ff[0];
   assign tmp1 = work_ff[7] + big1(work_ff[4])
               + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
               + sched_ff[0];
   assign tmp2 = big0(work_ff[0])
               + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                  ^ (work_ff[1] & work_ff[2]));

   // message bytes shift in at the tail, the schedule shifts out by words
   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         round_ff <= '0;
         for (int i = 0; i < DigestWords; i++) begin
            work_ff[i] <= hash_ff[i];
         end
      end else if (cmd.round_step) begin
         round_ff   <= round_ff + 1'b1;
         work_ff[0] <= tmp1 + k_word + tmp2;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3] + tmp1 + k_word;
         work_ff[5] <= work_ff[4];
         work_ff[6] <= work_ff[5];
         work_ff[7] <= work_ff[6];
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[15] <= sched_new;
      end else if (cmd.write_byte) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_ff[15] <= {sched_ff[15][23:0], cmd.byte_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reload_iv) begin
         for (int i = 0; i < DigestWords; i++) begin
            hash_ff[i] <= InitHash[i];
         end
      end else if (cmd.update_hash) begin
         for (int i = 0; i < DigestWords; i++) begin
            hash_ff[i] <= hash_ff[i] + work_ff[i];
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sha_control.sv
// sequencer for absorb, padding, rounds and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha_control (
   input  wire logic              clock,
   input  wire logic              reset,
   sha_req_if.sink                req,
   sha_rsp_if.source              rsp,
   input  wire logic [5:0]        count_pos,
   input  wire logic [63:0]       msg_bits,
   input  wire logic [31:0]       hash_word,
   output sha_pkg::cmd_type       cmd,
   output logic [2:0]             out_sel
);
   import sha_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] addr_ff, addr_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       finish_ff, finish_in;
   logic       second_ff, second_in;
   logic       accept;

   assign accept  = req.valid && req.ready;
   assign out_sel = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         addr_ff   <= '0;
         round_ff  <= '0;
         word_ff   <= '0;
         finish_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         round_ff  <= round_in;
         word_ff   <= word_in;
         finish_ff <= finish_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      round_in   = round_ff;
      word_in    = word_ff;
      finish_in  = finish_ff;
      second_in  = second_ff;
      cmd        = '0;
      req.ready  = 1'b0;
      rsp.valid  = 1'b0;
      rsp.payload.digest_word = hash_word;
      rsp.payload.word_index  = word_ff;
      rsp.payload.last_word   = (word_ff == 3'(DigestWords - 1));
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (accept) begin
               cmd.write_byte = 1'b1;
               if (req.payload.operation == OP_ABSORB) begin
                  cmd.byte_value = req.payload.data_byte;
                  cmd.count_inc  = 1'b1;
                  finish_in      = 1'b0;
                  if (count_pos == 6'(BlockBytes - 1)) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  cmd.byte_value = 8'h80;
                  finish_in      = 1'b1;
                  second_in      = (count_pos >= 6'd56);
                  addr_in        = count_pos + 1'b1;
                  state_in       = (count_pos == 6'(BlockBytes - 1)) ? ST_LOAD : ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.write_byte = 1'b1;
            cmd.byte_value = 8'h00;
            if (!second_ff && addr_ff >= 6'd56) begin
               cmd.byte_value = msg_bits[{~addr_ff[2:0], 3'b000} +: 8];
            end
            addr_in = addr_ff + 1'b1;
            if (addr_ff == 6'(BlockBytes - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            round_in       = round_ff + 1'b1;
            if (round_ff == 6'(RoundCount - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_hash = 1'b1;
            word_in         = '0;
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (second_ff) begin
               second_in = 1'b0;
               addr_in   = '0;
               state_in  = ST_PAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               word_in = word_ff + 1'b1;
               if (word_ff == 3'(DigestWords - 1)) begin
                  cmd.reload_iv   = 1'b1;
                  cmd.count_clear = 1'b1;
                  finish_in       = 1'b0;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_emit_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> finish_ff) else $error("digest without finish");
   a_last_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.payload.last_word |=> state_ff == ST_IDLE)
      else $error("emit did not end");

endmodule
`default_nettype wire

FILE: tb/sv/sha256_byte_stream_hasher_core_tb.sv
// testbench for the sha-256 byte stream hasher with a built-in digest predictor
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core_tb;
   import sha_pkg::*;

   localparam int HoldCycles = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha_req_if req_ch ();
   sha_rsp_if rsp_ch ();

   sha256_byte_stream_hasher_core u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   always #5 clock = ~clock;

   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_len;
   rsp_type     digest_queue [$];

   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_taken = 0;
   int hold_left = 0;
   bit timed_out = 1'b0;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a [8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) a[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = a[7] + (rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25))
            + ((a[4] & a[5]) ^ (~a[4] & a[6])) + RoundK[t] + w[t];
         t2 = (rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22))
            + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
         a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
         a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += a[i];
   endtask

   task automatic predict_digest(input req_type item);
      int pos;
      logic [63:0] bits;
      rsp_type r;
      pos = int'(msg_len[5:0]);
      if (op_type'(item.operation) == OP_ABSORB) begin
         msg_block[pos] = item.data_byte;
         msg_len = msg_len + 1;
         if (pos == 63) compress_block();
      end else begin
         bits = {msg_len, 3'b000};
         msg_block[pos] = 8'h80;
         pos++;
         if (pos > 56) begin
            for (; pos < 64; pos++) msg_block[pos] = 8'h00;
            compress_block();
            pos = 0;
         end
         for (; pos < 56; pos++) msg_block[pos] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_state[i];
            r.word_index = 3'(i);
            r.last_word = (i == 7);
            digest_queue.push_back(r);
         end
         for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
         msg_len = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("error %0t: %s got %h expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input op_type op, input logic [7:0] data);
      req_type item;
      item.operation = op;
      item.data_byte = data;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      predict_digest(item);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (digest_queue.size() != 0 && !timed_out) @(posedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(255)));
      send_item(OP_FINISH, 8'($urandom_range(255)));
   endtask

   // result checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.payload.digest_word, '0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_ch.payload.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_ch.payload.digest_word, want.digest_word);
            if (rsp_ch.payload.word_index !== want.word_index)
               report_mismatch("word_index", 32'(rsp_ch.payload.word_index),
                               32'(want.word_index));
            if (rsp_ch.payload.last_word !== want.last_word)
               report_mismatch("last_word", 32'(rsp_ch.payload.last_word),
                               32'(want.last_word));
         end
      end
   end

   // receiver stall and long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken <= hold_requests;
         hold_left <= HoldCycles;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000 && !timed_out) begin
         timed_out = 1'b1;
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(OP_FINISH, 8'h00);
      send_item(OP_FINISH, 8'hff);
      send_item(OP_ABSORB, 8'h61);
      send_item(OP_ABSORB, 8'h62);
      send_item(OP_ABSORB, 8'h63);
      send_item(OP_FINISH, 8'h00);
      send_item(OP_ABSORB, 8'hff);
      send_item(OP_ABSORB, 8'h00);
      send_item(OP_ABSORB, 8'haa);
      send_item(OP_ABSORB, 8'h55);
      send_item(OP_FINISH, 8'h5a);
      wait_drained();
   endtask

   // padding boundaries: 55 fits, 63 spills with the marker in the last byte
   task automatic test_padding_edges();
      send_message(55);
      send_message(63);
      wait_drained();
   endtask

   task automatic test_random(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(0, 6);
         send_message(len);
         sent += len + 1;
      end
      wait_drained();
   endtask

   task automatic test_back_pressure();
      hold_requests++;
      send_message(6);
      send_message(3);
      wait_drained();
   endtask

   initial begin
      req_type idle_item;
      idle_item = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = idle_item;
      for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      msg_len = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_padding_edges();
      send_idle_pct = 84;
      test_random(8);
      send_idle_pct = 0;
      recv_stall_pct = 84;
      test_random(8);
      send_idle_pct = 22;
      recv_stall_pct = 22;
      test_random(8);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_back_pressure();
      repeat (200) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
